/* rtl/core/pls_pkg.sv */
// Shared types and constants for the pyrometer layer segmenter.
// No dependencies; used by the channel interfaces and the core.
package pls_pkg;

  localparam int unsigned WINDOW_LEN = 20000;
  localparam int unsigned POS_W      = $clog2(WINDOW_LEN);
  localparam int unsigned TEMP_W     = 24;
  localparam int unsigned TOTAL_W    = TEMP_W + POS_W;
  localparam int unsigned ACT_W      = 20;
  localparam int unsigned LAYER_W    = 16;
  localparam int unsigned INDEX_W    = 32;
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [TEMP_W-1:0]  WIN_RESET_VAL = TEMP_W'(5000 * 256);
  localparam logic [TOTAL_W-1:0] TOTAL_RESET   =
    TOTAL_W'(WINDOW_LEN) * TOTAL_W'(WIN_RESET_VAL);
  localparam logic [POS_W-1:0]   POS_LAST      = POS_W'(WINDOW_LEN - 1);

  localparam logic [15:0]        GAIN_RESET     = 16'd40146;
  localparam logic [23:0]        OFFSET_RESET   = 24'd1261495;
  localparam logic [15:0]        MIN_TEMP_RESET = 16'd4928;
  localparam logic [15:0]        START_RESET    = 16'd5020;
  localparam logic [15:0]        END_RESET      = 16'd5010;
  localparam logic [ACT_W-1:0]   MIN_ACT_RESET  = ACT_W'(20000);
  localparam logic [TOTAL_W-1:0] END_LIMIT_RESET =
    TOTAL_W'({END_RESET, 8'h00}) * TOTAL_W'(WINDOW_LEN);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN      = 3'd0,
    CFG_OFFSET    = 3'd1,
    CFG_MIN_TEMP  = 3'd2,
    CFG_START_THR = 3'd3,
    CFG_END_THR   = 3'd4,
    CFG_MIN_ACT   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_START = 2'd1,
    EVT_END   = 2'd2
  } event_e;

  typedef struct packed {
    logic                accepted;
    logic [1:0]          event_res;
    logic [LAYER_W-1:0]  layer_number;
    logic [INDEX_W-1:0]  sample_index;
    logic [TEMP_W-1:0]   temperature;
  } result_t;

endpackage

/* rtl/core/pls_if.sv */
// Valid/ready channel interfaces for raw samples and segmenter results.
// Depends on pls_pkg.
interface pls_in_if;
  logic                       valid;
  logic                       ready;
  logic [pls_pkg::RAW_W-1:0]  raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface pls_out_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic [1:0]                   event_res;
  logic [pls_pkg::LAYER_W-1:0]  layer_number;
  logic [pls_pkg::INDEX_W-1:0]  sample_index;
  logic [pls_pkg::TEMP_W-1:0]   temperature;

  modport source (output valid, output accepted, output event_res, output layer_number,
                  output sample_index, output temperature, input ready);
  modport sink   (input valid, input accepted, input event_res, input layer_number,
                  input sample_index, input temperature, output ready);
endinterface

/* rtl/core/pyrometer_layer_segmenter.sv */
// Pyrometer layer segmenter: sample conversion, ring-window mean and layer state.
// Depends on pls_pkg and the channel interfaces in pls_if.sv.
//
// Each raw sample becomes one result word, in order. The stages are: input
// register, gain multiply, offset/saturate/threshold compares, and the result
// register, which is loaded together with the window and layer state update.
// One word per cycle is sustained while result_if.ready stays high: the window
// memory has one write and one registered read port, and the read for the next
// accepted sample is issued at the same edge as the write of the current one.
// The window reads as 5000.0 per entry until the write pointer first wraps, so
// no clearing pass runs after reset and samples are taken from the first cycle.
// Configuration is written through cfg_we_i; indexes beyond the register list
// are ignored.
module pyrometer_layer_segmenter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pls_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pls_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  pls_in_if.sink                         sample_if,
  pls_out_if.source                      result_if
);
  import pls_pkg::*;

  // configuration
  logic [15:0]        gain_q;
  logic [23:0]        offset_q;
  logic [15:0]        min_temp_q;
  logic [15:0]        start_thr_q;
  logic [TOTAL_W-1:0] end_limit_q;
  logic [ACT_W-1:0]   min_act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= GAIN_RESET;
      offset_q    <= OFFSET_RESET;
      min_temp_q  <= MIN_TEMP_RESET;
      start_thr_q <= START_RESET;
      end_limit_q <= END_LIMIT_RESET;
      min_act_q   <= MIN_ACT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN:      gain_q      <= cfg_wdata_i[15:0];
        CFG_OFFSET:    offset_q    <= cfg_wdata_i[23:0];
        CFG_MIN_TEMP:  min_temp_q  <= cfg_wdata_i[15:0];
        CFG_START_THR: start_thr_q <= cfg_wdata_i[15:0];
        // mean test is done on the sum: keep threshold * 256 * window length
        CFG_END_THR:   end_limit_q <= TOTAL_W'({cfg_wdata_i[15:0], 8'h00}) *
                                      TOTAL_W'(WINDOW_LEN);
        CFG_MIN_ACT:   min_act_q   <= cfg_wdata_i[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline valids and flow control
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic out_free, free3, free2, free1, adv3;

  assign out_free        = !out_v_q || result_if.ready;
  assign free3           = !s3_v_q || out_free;
  assign free2           = !s2_v_q || free3;
  assign free1           = !s1_v_q || free2;
  assign adv3            = s3_v_q && out_free;
  assign sample_if.ready = free1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (free1) s1_v_q  <= sample_if.valid;
      if (free2) s2_v_q  <= s1_v_q;
      if (free3) s3_v_q  <= s2_v_q;
      if (out_free) out_v_q <= s3_v_q;
    end
  end

  // datapath stages
  logic [RAW_W-1:0]   raw_q;
  logic [31:0]        prod_q;
  logic [TEMP_W-1:0]  temp_q;
  logic               acc_q;
  logic               hot_q;
  logic [TEMP_W:0]    temp_sum;
  logic [TEMP_W-1:0]  temp_sat;

  assign temp_sum = {1'b0, prod_q[31:8]} + {1'b0, offset_q};
  assign temp_sat = temp_sum[TEMP_W] ? '1 : temp_sum[TEMP_W-1:0];

  always_ff @(posedge clk_i) begin
    if (free1) raw_q  <= sample_if.raw_sample;
    if (free2) prod_q <= 32'(raw_q) * 32'(gain_q);
    if (free3) begin
      temp_q <= temp_sat;
      acc_q  <= temp_sat > {min_temp_q, 8'h00};
      hot_q  <= temp_sat > {start_thr_q, 8'h00};
    end
  end

  // window and layer state
  logic [POS_W-1:0]   pos_q, pos_d, pos_inc;
  logic               wrapped_q;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               idle_q;
  logic [ACT_W-1:0]   act_q, act_mid, act_inc;
  logic [LAYER_W-1:0] layer_q;
  logic [INDEX_W-1:0] count_q;
  logic [TEMP_W-1:0]  rd_q, old_val;
  logic               take, start, idle_mid, fin;
  result_t            res_d, res_q;

  assign take     = adv3 && acc_q;
  assign start    = idle_q && hot_q;
  assign idle_mid = idle_q && !start;
  assign pos_inc  = (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
  assign pos_d    = take ? pos_inc : pos_q;
  // entries not yet written since reset are read as the reset value
  assign old_val  = wrapped_q ? rd_q : WIN_RESET_VAL;
  assign total_d  = total_q + TOTAL_W'(temp_q) - TOTAL_W'(old_val);
  assign act_mid  = start ? '0 : act_q;
  assign act_inc  = (!idle_mid && act_mid != '1) ? act_mid + ACT_W'(1) : act_mid;
  assign fin      = !idle_mid && (act_inc > min_act_q) && (total_d < end_limit_q);

  logic [TEMP_W-1:0] win_mem [WINDOW_LEN];

  always_ff @(posedge clk_i) begin
    if (take) win_mem[pos_q] <= temp_q;
    rd_q <= win_mem[pos_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      wrapped_q <= 1'b0;
      total_q   <= TOTAL_RESET;
      idle_q    <= 1'b1;
      act_q     <= '0;
      layer_q   <= '0;
      count_q   <= '0;
    end else if (take) begin
      pos_q   <= pos_inc;
      if (pos_q == POS_LAST) wrapped_q <= 1'b1;
      total_q <= total_d;
      idle_q  <= fin ? 1'b1 : idle_mid;
      act_q   <= fin ? '0 : act_inc;
      layer_q <= layer_q + LAYER_W'(start);
      count_q <= count_q + INDEX_W'(1);
    end
  end

  always_comb begin
    res_d.accepted     = acc_q;
    res_d.event_res    = EVT_NONE;
    res_d.layer_number = layer_q;
    res_d.sample_index = count_q;
    res_d.temperature  = temp_q;
    if (acc_q) begin
      if (fin) begin
        res_d.event_res = EVT_END;
      end else if (start) begin
        res_d.event_res = EVT_START;
      end
      res_d.layer_number = layer_q + LAYER_W'(start);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) res_q <= res_d;
  end

  assign result_if.valid        = out_v_q;
  assign result_if.accepted     = res_q.accepted;
  assign result_if.event_res    = res_q.event_res;
  assign result_if.layer_number = res_q.layer_number;
  assign result_if.sample_index = res_q.sample_index;
  assign result_if.temperature  = res_q.temperature;

endmodule
